FILE: hw/rtl/xild_pkg.sv
// ----------------------------------------------------------------------------
// x86 length decoder package
// Shared widths, opcode class types and the byte-level decode functions used
// by the length decoder pipeline and its channel interfaces.
// ----------------------------------------------------------------------------
package xild_pkg;

  // Fixed payload widths of the channels.
  localparam int unsigned WORD_W = 64;
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned MAX_BYTES = 16;

  // Width of a byte position: holds positions up to MAX_BYTES + 3.
  localparam int unsigned PTR_W = 5;

  // Legacy, segment and size prefix bytes.
  localparam logic [7:0] PFX_OPSIZE = 8'h66;
  localparam logic [7:0] PFX_ADSIZE = 8'h67;
  localparam logic [7:0] PFX_LOCK   = 8'hF0;
  localparam logic [7:0] PFX_REPNE  = 8'hF2;
  localparam logic [7:0] PFX_REP    = 8'hF3;
  localparam logic [7:0] PFX_CS     = 8'h2E;
  localparam logic [7:0] PFX_SS     = 8'h36;
  localparam logic [7:0] PFX_DS     = 8'h3E;
  localparam logic [7:0] PFX_ES     = 8'h26;
  localparam logic [7:0] PFX_FS     = 8'h64;
  localparam logic [7:0] PFX_GS     = 8'h65;

  // Two-byte opcode escape.
  localparam logic [7:0] OP_ESCAPE = 8'h0F;

  // How the length of an opcode is formed.
  typedef enum logic [1:0] {
    CLS_BAD,    // not recognized
    CLS_FIXED,  // opcode bytes plus immediate
    CLS_MODRM,  // opcode bytes plus ModR/M group plus immediate
    CLS_ESC     // two-byte escape
  } op_class_t;

  typedef struct packed {
    op_class_t  cls;
    logic [2:0] imm;
  } op_info_t;

  typedef logic [7:0] byte_t;

  function automatic logic is_prefix(input byte_t b);
    return (b == PFX_OPSIZE) || (b == PFX_ADSIZE) || (b == PFX_LOCK) ||
           (b == PFX_REPNE)  || (b == PFX_REP)    || (b == PFX_CS)   ||
           (b == PFX_SS)     || (b == PFX_DS)     || (b == PFX_ES)   ||
           (b == PFX_FS)     || (b == PFX_GS);
  endfunction

  // Class and immediate size of a one-byte opcode.
  function automatic op_info_t op1_info(input byte_t op);
    op_info_t info;
    info = '{cls: CLS_BAD, imm: 3'd0};
    if (op[7:4] == 4'h5) begin
      info = '{cls: CLS_FIXED, imm: 3'd0};
    end else if (op[7:3] == 5'b10111) begin
      info = '{cls: CLS_FIXED, imm: 3'd4};
    end else begin
      case (op)
        8'h90, 8'hC3, 8'hCC, 8'hC9: info = '{cls: CLS_FIXED, imm: 3'd0};
        8'h6A, 8'hEB:               info = '{cls: CLS_FIXED, imm: 3'd1};
        8'h68, 8'hE9, 8'hE8:        info = '{cls: CLS_FIXED, imm: 3'd4};
        8'hC2:                      info = '{cls: CLS_FIXED, imm: 3'd2};
        8'h88, 8'h8A, 8'h89, 8'h8B, 8'h84, 8'h85, 8'h8D,
        8'h01, 8'h03, 8'h29, 8'h2B, 8'h31, 8'h33, 8'h39, 8'h3B,
        8'hFF:                      info = '{cls: CLS_MODRM, imm: 3'd0};
        8'h83:                      info = '{cls: CLS_MODRM, imm: 3'd1};
        8'h81:                      info = '{cls: CLS_MODRM, imm: 3'd4};
        OP_ESCAPE:                  info = '{cls: CLS_ESC,   imm: 3'd0};
        default:                    info = '{cls: CLS_BAD,   imm: 3'd0};
      endcase
    end
    return info;
  endfunction

  // Class and immediate size of the second byte after the escape.
  function automatic op_info_t op2_info(input byte_t op);
    op_info_t info;
    info = '{cls: CLS_BAD, imm: 3'd0};
    if (op[7:4] == 4'h8) begin
      // Near conditional jumps carry a 32-bit offset.
      info = '{cls: CLS_FIXED, imm: 3'd4};
    end else begin
      case (op)
        8'h1F, 8'hB6, 8'hB7, 8'hBE, 8'hBF, 8'hAF:
                 info = '{cls: CLS_MODRM, imm: 3'd0};
        default: info = '{cls: CLS_BAD,   imm: 3'd0};
      endcase
    end
    return info;
  endfunction

  // True when the ModR/M byte is followed by a SIB byte.
  function automatic logic needs_sib(input byte_t modrm);
    return (modrm[7:6] != 2'd3) && (modrm[2:0] == 3'd4);
  endfunction

  // Bytes taken by ModR/M, SIB and displacement.
  function automatic logic [3:0] operand_len(input byte_t modrm, input byte_t sib);
    logic [3:0] len;
    len = 4'd1;
    if (needs_sib(modrm)) begin
      len = len + 4'd1;
      if ((modrm[7:6] == 2'd0) && (sib[2:0] == 3'd5)) begin
        len = len + 4'd4;
      end
    end
    case (modrm[7:6])
      2'd0:    len = (modrm[2:0] == 3'd5) ? len + 4'd4 : len;
      2'd1:    len = len + 4'd1;
      2'd2:    len = len + 4'd4;
      default: len = len;
    endcase
    return len;
  endfunction

endpackage

FILE: hw/rtl/xild_if.sv
// ----------------------------------------------------------------------------
// x86 length decoder channel interfaces
// Valid/ready channels for code window requests and length results.
// ----------------------------------------------------------------------------
interface xild_in_if import xild_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] bytes_low;
  logic [WORD_W-1:0] bytes_high;

  modport source (output valid, output bytes_low, output bytes_high, input ready);
  modport sink   (input valid, input bytes_low, input bytes_high, output ready);
endinterface

interface xild_out_if import xild_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] insn_length;

  modport source (output valid, output insn_length, input ready);
  modport sink   (input valid, input insn_length, output ready);
endinterface

FILE: hw/rtl/x86_insn_length_decode_unit.sv
// An accepted request is registered in stages 1, 2 and 3 before its result shows on out_if.
// Throughput: one request per cycle while out_if is ready; each stage holds only
// while the stage after it is full and stalled, and ready runs back combinationally.
// The critical stage is the prefix-run priority search over the window.
// Reset clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// x86 instruction length decode unit
// Three-stage pipeline: prefix skip, byte select, opcode decode and sum.
// ----------------------------------------------------------------------------
module x86_insn_length_decode_unit import xild_pkg::*; #(
  parameter int unsigned WINDOW_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  xild_in_if.sink    in_if,
  xild_out_if.source out_if
);

  localparam logic [PTR_W-1:0] WIN_END = PTR_W'(WINDOW_BYTES);

  // Stage handshake: a stage may load when empty or when it moves on.
  logic s1_v_r, s2_v_r, s3_v_r;
  logic s1_free, s2_free, s3_free;

  assign s3_free     = !s3_v_r || out_if.ready;
  assign s2_free     = !s2_v_r || s3_free;
  assign s1_free     = !s1_v_r || s2_free;
  assign in_if.ready = s1_free;

  // Stage 1: find the first byte of the window that is not a prefix.
  logic [2*WORD_W-1:0] win_bits;
  byte_t               win [MAX_BYTES];
  logic [PTR_W-1:0]    pfx_end;

  always_comb begin
    win_bits = {in_if.bytes_high, in_if.bytes_low};
    for (int i = 0; i < MAX_BYTES; i++) begin
      win[i] = win_bits[8*i +: 8];
    end
    pfx_end = WIN_END;
    for (int i = WINDOW_BYTES - 1; i >= 0; i--) begin
      if (!is_prefix(win[i])) begin
        pfx_end = PTR_W'(i);
      end
    end
  end

  byte_t            s1_win_r [MAX_BYTES];
  logic [PTR_W-1:0] s1_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_if.valid;
    end
    if (s1_free && in_if.valid) begin
      s1_win_r <= win;
      s1_n_r   <= pfx_end;
    end
  end

  // Stage 2: pick the opcode byte and the three bytes after it.
  logic [PTR_W-1:0] pos [4];
  byte_t            pick_nxt [4];
  logic [3:0]       inwin_nxt;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pos[k]       = s1_n_r + PTR_W'(k);
      inwin_nxt[k] = pos[k] < WIN_END;
      pick_nxt[k]  = s1_win_r[pos[k][3:0]];
    end
  end

  byte_t            s2_b_r [4];
  logic [3:0]       s2_inwin_r;
  logic [PTR_W-1:0] s2_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
    end
    if (s2_free && s1_v_r) begin
      s2_b_r     <= pick_nxt;
      s2_inwin_r <= inwin_nxt;
      s2_n_r     <= s1_n_r;
    end
  end

  // Stage 3: classify the opcode and add up the length.
  logic       is_esc;
  op_info_t   info1, info;
  byte_t      modrm, sib;
  logic       ok_modrm, ok_sib;
  logic [5:0] head;
  logic [5:0] len;

  always_comb begin
    info1    = op1_info(s2_b_r[0]);
    is_esc   = info1.cls == CLS_ESC;
    info     = is_esc ? op2_info(s2_b_r[1]) : info1;
    modrm    = is_esc ? s2_b_r[2] : s2_b_r[1];
    sib      = is_esc ? s2_b_r[3] : s2_b_r[2];
    ok_modrm = is_esc ? s2_inwin_r[2] : s2_inwin_r[1];
    ok_sib   = is_esc ? s2_inwin_r[3] : s2_inwin_r[2];
    head     = 6'(s2_n_r) + (is_esc ? 6'd2 : 6'd1);
    len      = 6'd0;
    if (s2_inwin_r[0] && (!is_esc || s2_inwin_r[1])) begin
      case (info.cls)
        CLS_FIXED: len = head + 6'(info.imm);
        CLS_MODRM: begin
          if (ok_modrm && (!needs_sib(modrm) || ok_sib)) begin
            len = head + 6'(operand_len(modrm, sib)) + 6'(info.imm);
          end
        end
        default:   len = 6'd0;
      endcase
    end
  end

  logic [LEN_W-1:0] s3_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_free) begin
      s3_v_r <= s2_v_r;
    end
    if (s3_free && s2_v_r) begin
      s3_len_r <= len[LEN_W-1:0];
    end
  end

  assign out_if.valid       = s3_v_r;
  assign out_if.insn_length = s3_len_r;

endmodule

FILE: hw/rtl/xild_checker.sv
// ----------------------------------------------------------------------------
// x86 length decoder port checker
// Watches the decoder's ports for reset, stall, flow and range behavior.
// ----------------------------------------------------------------------------
module xild_checker import xild_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [LEN_W-1:0] insn_length
);

  // No result is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // A stalled result holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(insn_length))
    else $error("stalled result changed");

  // With the output empty, the pipeline always takes a request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request refused with empty output");

  // A request reaches the output when the sink stays ready while it moves through.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after pipeline latency");

  // No length beyond the longest decodable instruction.
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> insn_length <= LEN_W'(24))
    else $error("length out of range");

endmodule

bind x86_insn_length_decode_unit xild_checker u_xild_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .insn_length (out_if.insn_length)
);

FILE: test/x86_insn_length_decode_unit_tb.sv
// ----------------------------------------------------------------------------
// x86 instruction length decode unit testbench
// Sends 16-byte code windows through the valid/ready request channel and
// checks every returned length against a predictor of the decode rules.
// Directed windows cover the opcode classes, the addressing forms and the
// window bound. Random windows are mostly prefixed, well-formed instructions
// with random operand bytes, plus some pure noise. Both sides idle in random
// bursts, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module x86_insn_length_decode_unit_tb import xild_pkg::*; ();

  localparam int unsigned WIN = 16;
  localparam int unsigned RANDOM_WINDOWS = 1230;

  // One-byte opcodes.
  localparam byte_t OP_PUSH_R   = 8'h50;  // first of the register push group
  localparam byte_t OP_MOV_RI   = 8'hB8;  // first of the register/imm32 moves
  localparam byte_t OP_NOP      = 8'h90;
  localparam byte_t OP_RET      = 8'hC3;
  localparam byte_t OP_INT3     = 8'hCC;
  localparam byte_t OP_LEAVE    = 8'hC9;
  localparam byte_t OP_PUSH_I8  = 8'h6A;
  localparam byte_t OP_JMP_R8   = 8'hEB;
  localparam byte_t OP_PUSH_I32 = 8'h68;
  localparam byte_t OP_JMP_R32  = 8'hE9;
  localparam byte_t OP_CALL     = 8'hE8;
  localparam byte_t OP_RET_I16  = 8'hC2;
  localparam byte_t OP_MOV_MR8  = 8'h88;
  localparam byte_t OP_MOV_RM8  = 8'h8A;
  localparam byte_t OP_MOV_MR   = 8'h89;
  localparam byte_t OP_MOV_RM   = 8'h8B;
  localparam byte_t OP_TEST8    = 8'h84;
  localparam byte_t OP_TEST     = 8'h85;
  localparam byte_t OP_LEA      = 8'h8D;
  localparam byte_t OP_ADD_MR   = 8'h01;
  localparam byte_t OP_ADD_RM   = 8'h03;
  localparam byte_t OP_SUB_MR   = 8'h29;
  localparam byte_t OP_SUB_RM   = 8'h2B;
  localparam byte_t OP_XOR_MR   = 8'h31;
  localparam byte_t OP_XOR_RM   = 8'h33;
  localparam byte_t OP_CMP_MR   = 8'h39;
  localparam byte_t OP_CMP_RM   = 8'h3B;
  localparam byte_t OP_GRP5     = 8'hFF;
  localparam byte_t OP_GRP1_I8  = 8'h83;
  localparam byte_t OP_GRP1_I32 = 8'h81;
  localparam int unsigned NUM_ONE_OPS = 30;

  // Second bytes after the escape.
  localparam byte_t OP_JCC_NEAR = 8'h80;  // first of the near conditional jumps
  localparam byte_t OP_NOP_RM   = 8'h1F;
  localparam byte_t OP_MOVZX8   = 8'hB6;
  localparam byte_t OP_MOVZX16  = 8'hB7;
  localparam byte_t OP_MOVSX8   = 8'hBE;
  localparam byte_t OP_MOVSX16  = 8'hBF;
  localparam byte_t OP_IMUL_RM  = 8'hAF;
  localparam byte_t OP_ESC_BAD  = 8'h0B;
  localparam int unsigned NUM_ESC_OPS = 7;

  // ModR/M and SIB fields.
  localparam logic [1:0] MOD_IND = 2'd0;
  localparam logic [1:0] MOD_D8  = 2'd1;
  localparam logic [1:0] MOD_D32 = 2'd2;
  localparam logic [1:0] MOD_REG = 2'd3;
  localparam logic [2:0] RM_SIB  = 3'd4;
  localparam logic [2:0] RM_DISP = 3'd5;
  localparam logic [2:0] SIB_NO_BASE = 3'd5;

  logic clk;
  logic rst_n;

  xild_in_if  in_if ();
  xild_out_if out_if ();

  x86_insn_length_decode_unit #(.WINDOW_BYTES(WIN)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  logic [127:0]     code_windows[$];
  logic [LEN_W-1:0] pending_lengths[$];
  logic [127:0]     scratch;
  logic [127:0]     next_window;
  int               windows_sent;
  int               mismatches;
  int               src_gap;
  int               sink_gap;
  logic             calm;
  logic             hold_off;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Any legacy, segment or size prefix.
  function automatic logic is_legacy_prefix(input byte_t b);
    case (b)
      PFX_OPSIZE, PFX_ADSIZE, PFX_LOCK, PFX_REPNE, PFX_REP, PFX_CS, PFX_SS,
      PFX_DS, PFX_ES, PFX_FS, PFX_GS: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Bytes of ModR/M, SIB and displacement at pos; 0 when a byte that has to
  // be read falls outside the window.
  function automatic int unsigned operand_bytes(input logic [127:0] w,
                                                input int unsigned pos);
    byte_t m;
    byte_t sib;
    int unsigned len;
    if (pos >= WIN) return 0;
    m = w[8*pos +: 8];
    len = 1;
    if (m[7:6] != MOD_REG && m[2:0] == RM_SIB) begin
      if (pos + 1 >= WIN) return 0;
      sib = w[8*(pos+1) +: 8];
      len += 1;
      if (m[7:6] == MOD_IND && sib[2:0] == SIB_NO_BASE) len += 4;
    end
    case (m[7:6])
      MOD_IND: if (m[2:0] == RM_DISP) len += 4;
      MOD_D8:  len += 1;
      MOD_D32: len += 4;
      default: ;
    endcase
    return len;
  endfunction

  // Length of the first instruction in a window; 0 when not recognized.
  function automatic logic [LEN_W-1:0] decode_length(input logic [127:0] w);
    int unsigned n;
    int unsigned ol;
    int unsigned imm;
    int unsigned len;
    byte_t op;
    byte_t op2;
    logic use_modrm;
    n = 0;
    len = 0;
    imm = 0;
    use_modrm = 1'b0;
    while (n < WIN && is_legacy_prefix(w[8*n +: 8])) n++;
    if (n >= WIN) return '0;
    op = w[8*n +: 8];
    n++;
    if (op >= OP_PUSH_R && op <= OP_PUSH_R + 8'd15) begin
      len = n;
    end else if (op >= OP_MOV_RI && op <= OP_MOV_RI + 8'd7) begin
      len = n + 4;
    end else begin
      case (op)
        OP_NOP, OP_RET, OP_INT3, OP_LEAVE: len = n;
        OP_PUSH_I8, OP_JMP_R8:             len = n + 1;
        OP_PUSH_I32, OP_JMP_R32, OP_CALL:  len = n + 4;
        OP_RET_I16:                        len = n + 2;
        OP_MOV_MR8, OP_MOV_RM8, OP_MOV_MR, OP_MOV_RM, OP_TEST8, OP_TEST, OP_LEA,
        OP_ADD_MR, OP_ADD_RM, OP_SUB_MR, OP_SUB_RM, OP_XOR_MR, OP_XOR_RM,
        OP_CMP_MR, OP_CMP_RM, OP_GRP5:     use_modrm = 1'b1;
        OP_GRP1_I8: begin
          use_modrm = 1'b1;
          imm = 1;
        end
        OP_GRP1_I32: begin
          use_modrm = 1'b1;
          imm = 4;
        end
        OP_ESCAPE: begin
          if (n < WIN) begin
            op2 = w[8*n +: 8];
            n++;
            if ((op2 & 8'hF0) == OP_JCC_NEAR) begin
              len = n + 4;
            end else begin
              case (op2)
                OP_NOP_RM, OP_MOVZX8, OP_MOVZX16, OP_MOVSX8, OP_MOVSX16,
                OP_IMUL_RM: use_modrm = 1'b1;
                default: ;
              endcase
            end
          end
        end
        default: len = 0;
      endcase
    end
    if (use_modrm) begin
      ol = operand_bytes(w, n);
      len = (ol == 0) ? 0 : n + ol + imm;
    end
    return len[LEN_W-1:0];
  endfunction

  // Window building helpers.
  function automatic byte_t any_prefix();
    case ($urandom_range(0, 10))
      0:       return PFX_OPSIZE;
      1:       return PFX_ADSIZE;
      2:       return PFX_LOCK;
      3:       return PFX_REPNE;
      4:       return PFX_REP;
      5:       return PFX_CS;
      6:       return PFX_SS;
      7:       return PFX_DS;
      8:       return PFX_ES;
      9:       return PFX_FS;
      default: return PFX_GS;
    endcase
  endfunction

  function automatic byte_t one_byte_op(input int unsigned k);
    case (k)
      0:       return OP_NOP;
      1:       return OP_RET;
      2:       return OP_INT3;
      3:       return OP_LEAVE;
      4:       return OP_PUSH_I8;
      5:       return OP_JMP_R8;
      6:       return OP_PUSH_I32;
      7:       return OP_JMP_R32;
      8:       return OP_CALL;
      9:       return OP_RET_I16;
      10:      return OP_MOV_MR8;
      11:      return OP_MOV_RM8;
      12:      return OP_MOV_MR;
      13:      return OP_MOV_RM;
      14:      return OP_TEST8;
      15:      return OP_TEST;
      16:      return OP_LEA;
      17:      return OP_ADD_MR;
      18:      return OP_ADD_RM;
      19:      return OP_SUB_MR;
      20:      return OP_SUB_RM;
      21:      return OP_XOR_MR;
      22:      return OP_XOR_RM;
      23:      return OP_CMP_MR;
      24:      return OP_CMP_RM;
      25:      return OP_GRP5;
      26:      return OP_GRP1_I8;
      27:      return OP_GRP1_I32;
      28:      return byte_t'(OP_PUSH_R + $urandom_range(0, 15));
      default: return byte_t'(OP_MOV_RI + $urandom_range(0, 7));
    endcase
  endfunction

  function automatic byte_t escape_op(input int unsigned k);
    case (k)
      0:       return byte_t'(OP_JCC_NEAR + $urandom_range(0, 15));
      1:       return OP_NOP_RM;
      2:       return OP_MOVZX8;
      3:       return OP_MOVZX16;
      4:       return OP_MOVSX8;
      5:       return OP_MOVSX16;
      default: return OP_IMUL_RM;
    endcase
  endfunction

  function automatic byte_t make_modrm(input logic [1:0] md, input logic [2:0] rm);
    return {md, 3'($urandom_range(0, 7)), rm};
  endfunction

  task automatic new_window();
    scratch = {$urandom, $urandom, $urandom, $urandom};
  endtask

  task automatic put_byte(input int unsigned pos, input byte_t b);
    if (pos < WIN) scratch[8*pos +: 8] = b;
  endtask

  task automatic put_prefixes(input int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) put_byte(i, any_prefix());
  endtask

  task automatic commit_window();
    code_windows.push_back(scratch);
  endtask

  // A prefixed instruction with random operand bytes; the prefix run may push
  // the opcode toward or past the end of the window.
  task automatic random_instruction(input int unsigned prefixes);
    new_window();
    put_prefixes(prefixes);
    if ($urandom_range(0, 9) < 2) begin
      put_byte(prefixes, OP_ESCAPE);
      if ($urandom_range(0, 7) == 0) put_byte(prefixes + 1, byte_t'($urandom));
      else put_byte(prefixes + 1, escape_op($urandom_range(0, NUM_ESC_OPS - 1)));
    end else begin
      put_byte(prefixes, one_byte_op($urandom_range(0, NUM_ONE_OPS - 1)));
    end
    commit_window();
  endtask

  // Request driver: presents queued windows and records the expected length
  // of each accepted request.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        pending_lengths.push_back(decode_length({in_if.bytes_high, in_if.bytes_low}));
        windows_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_if.valid <= 1'b0;
        end else if (code_windows.size() > 0) begin
          next_window = code_windows.pop_front();
          in_if.bytes_low  <= next_window[63:0];
          in_if.bytes_high <= next_window[127:64];
          in_if.valid      <= 1'b1;
          if (!calm && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 12);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each length in order and drives ready with
  // random stall bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_lengths.size() == 0) begin
          $error("insn_length: expected none, actual %0d", out_if.insn_length);
          mismatches++;
        end else if (pending_lengths[0] !== out_if.insn_length) begin
          $error("insn_length: expected %0d, actual %0d",
                 pending_lengths[0], out_if.insn_length);
          mismatches++;
          void'(pending_lengths.pop_front());
        end else begin
          void'(pending_lengths.pop_front());
        end
      end
      if (hold_off) begin
        out_if.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 12);
      end
    end
  end

  // One long receiver hold-off while requests keep coming, to fill the pipe.
  initial begin
    hold_off = 1'b0;
    while (windows_sent < 300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (80) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Stimulus and end of run.
  initial begin
    int unsigned i;
    int unsigned pick;
    in_if.valid      = 1'b0;
    in_if.bytes_low  = '0;
    in_if.bytes_high = '0;
    out_if.ready     = 1'b0;
    rst_n            = 1'b0;
    calm             = 1'b0;
    windows_sent     = 0;
    mismatches       = 0;

    // Extremes of the input words.
    scratch = '0;
    commit_window();
    scratch = '1;
    commit_window();

    // Fixed-length opcodes, register groups included.
    new_window(); put_byte(0, OP_NOP); commit_window();
    new_window(); put_prefixes(1);
    put_byte(1, byte_t'(OP_PUSH_R + $urandom_range(0, 15))); commit_window();
    new_window(); put_byte(0, byte_t'(OP_MOV_RI + 8'd7)); commit_window();
    new_window(); put_byte(0, OP_PUSH_I8); commit_window();
    new_window(); put_prefixes(2); put_byte(2, OP_RET_I16); commit_window();
    new_window(); put_byte(0, OP_CALL); commit_window();

    // ModR/M addressing forms and immediates.
    new_window(); put_byte(0, OP_MOV_RM);
    put_byte(1, make_modrm(MOD_IND, RM_DISP)); commit_window();
    new_window(); put_byte(0, OP_LEA); put_byte(1, make_modrm(MOD_IND, RM_SIB));
    put_byte(2, {5'($urandom_range(0, 31)), SIB_NO_BASE}); commit_window();
    new_window(); put_byte(0, OP_ADD_MR); put_byte(1, make_modrm(MOD_D8, RM_SIB));
    commit_window();
    new_window(); put_byte(0, OP_GRP1_I8); put_byte(1, make_modrm(MOD_D8, 3'd0));
    commit_window();
    new_window(); put_byte(0, OP_GRP1_I32); put_byte(1, make_modrm(MOD_D32, RM_DISP));
    commit_window();

    // Two-byte opcodes: jump, ModR/M form and an unknown one.
    new_window(); put_byte(0, OP_ESCAPE); put_byte(1, escape_op(0)); commit_window();
    new_window(); put_byte(0, OP_ESCAPE); put_byte(1, OP_MOVZX8);
    put_byte(2, make_modrm(MOD_REG, RM_SIB)); commit_window();
    new_window(); put_byte(0, OP_ESCAPE); put_byte(1, OP_ESC_BAD); commit_window();

    // Window bound: all prefixes, opcode bytes cut off, operand bytes cut
    // off, and the longest lengths that still fit.
    new_window(); put_prefixes(16); commit_window();
    new_window(); put_prefixes(15); put_byte(15, OP_ESCAPE); commit_window();
    new_window(); put_prefixes(14); put_byte(14, OP_ESCAPE); put_byte(15, OP_NOP_RM);
    commit_window();
    new_window(); put_prefixes(15); put_byte(15, OP_MOV_MR); commit_window();
    new_window(); put_prefixes(14); put_byte(14, OP_MOV_MR);
    put_byte(15, make_modrm(MOD_IND, RM_SIB)); commit_window();
    new_window(); put_prefixes(14); put_byte(14, OP_GRP1_I32);
    put_byte(15, make_modrm(MOD_D32, RM_DISP)); commit_window();
    new_window(); put_prefixes(13); put_byte(13, OP_MOV_MR);
    put_byte(14, make_modrm(MOD_IND, RM_SIB));
    put_byte(15, {5'($urandom_range(0, 31)), SIB_NO_BASE}); commit_window();

    // Random part: mostly well-formed instructions, some with long prefix
    // runs near the window end, and some pure noise.
    for (i = 0; i < RANDOM_WINDOWS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        new_window();
        commit_window();
      end else if (pick < 25) begin
        random_instruction($urandom_range(10, 16));
      end else begin
        random_instruction($urandom_range(0, 3));
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // No idling for the last part of the run.
    while (code_windows.size() >= 150) @(posedge clk);
    calm <= 1'b1;

    while (code_windows.size() != 0 || in_if.valid || pending_lengths.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_lengths.size() == 0) begin
      $display("x86_insn_length_decode_unit test passed");
    end else begin
      $display("x86_insn_length_decode_unit test failed");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #400000;
    $display("x86_insn_length_decode_unit test failed");
    $finish;
  end

endmodule
